[hdl/lidtpf_pkg.sv]
// Shared constants, types and lookup tables of the lidar trailing point filter.
package lidtpf_pkg;

  localparam int MAX_WINDOW_DEF = 15;
  localparam int DIST_W         = 16;
  localparam int THR_W          = 28;
  localparam int SIN_W          = 23;
  localparam int COS_W          = 30;
  localparam int FRAC_W         = 30;
  localparam int DEN_W          = DIST_W + FRAC_W;
  localparam int HALF_W         = DEN_W / 2;
  localparam int LIM_W          = 6;
  localparam int SEEN_W         = 5;
  localparam int WL_W           = 4;
  localparam int LVL_W          = 3;
  localparam int RATE_W         = 5;
  localparam int CFG_IDX_W      = 2;
  localparam int CFG_DATA_W     = 5;
  localparam int NEED_W         = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEVEL  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE   = 2'd2;

  localparam logic [SEEN_W-1:0] SEEN_MAX     = 5'd31;
  localparam logic [DIST_W-1:0] EXEMPT_RANGE = 16'd500;
  localparam logic [WL_W-1:0]   WL_RESET     = 4'd5;
  localparam logic [WL_W-1:0]   WL_MIN       = 4'd3;
  localparam logic [RATE_W-1:0] RATE_RESET   = 5'd10;

  typedef struct packed {
    logic              ok;
    logic [THR_W-1:0]  thr;
    logic [NEED_W-1:0] need;
  } level_t;

  typedef struct packed {
    logic             ok;
    logic [SIN_W-1:0] s;
    logic [COS_W-1:0] c;
    logic [LIM_W-1:0] limit;
  } rate_t;

  typedef struct packed {
    logic shift;
    logic ld_d;
    logic ld_prev;
    logic ld_den;
    logic ld_plo;
    logic cmp;
    logic side_left;
    logic clr_cnt;
    logic set_marks;
    logic emit;
    logic emit_last;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic              out_free;
    logic              enabled;
    logic              skip;
    logic              drop;
    logic [WL_W-2:0]   h;
    logic [SEEN_W-1:0] seen;
  } status_t;

  function automatic level_t level_lookup(input logic [LVL_W-1:0] lvl);
    level_t r;
    r = '0;
    unique case (lvl)
      3'd1: r = '{1'b1, 28'd56272425, 2'd3};
      3'd2: r = '{1'b1, 28'd56272425, 2'd2};
      3'd3: r = '{1'b1, 28'd103389578, 2'd2};
      3'd4: r = '{1'b1, 28'd170063998, 2'd2};
      3'd5: r = '{1'b1, 28'd170063998, 2'd1};
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic rate_t rate_lookup(input logic [RATE_W-1:0] rate);
    rate_t r;
    r = '0;
    unique case (rate)
      5'd10: r = '{1'b1, 23'd2226350, 30'd1073739516, 6'd15};
      5'd15: r = '{1'b1, 23'd3339521, 30'd1073736631, 6'd30};
      5'd20: r = '{1'b1, 23'd4452690, 30'd1073732592, 6'd25};
      5'd25: r = '{1'b1, 23'd5565853, 30'd1073727398, 6'd35};
      5'd30: r = '{1'b1, 23'd6679011, 30'd1073721051, 6'd40};
      default: r = '0;
    endcase
    return r;
  endfunction

endpackage

[hdl/lidar_trailing_point_filter.sv]
// Top level of the lidar trailing point filter.
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------
//  in      | in_valid_i / in_stall_o | distance_i, scan_end_i
//  out     | out_valid_o/out_stall_i | filtered_distance_o, scan_last_o
//  cfg     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One request at a time. A zero or exempt point leaves the test after the PREV and NEXT
// steps; otherwise each neighbor in a window of W is tested in turn with one shared
// multiplier pair (steps DEN, MLO, MHI per neighbor). On scan end the rest is flushed.
// Reset sets window 5, level 0, rate 10 and empties the window.
// A stalled output holds the sequencer; a waiting result does not block intake.
module lidar_trailing_point_filter #(
  parameter int MAX_WINDOW = lidtpf_pkg::MAX_WINDOW_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lidtpf_pkg::DIST_W-1:0]     distance_i,
  input  logic                              scan_end_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [lidtpf_pkg::DIST_W-1:0]     filtered_distance_o,
  output logic                              scan_last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [lidtpf_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [lidtpf_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int IW = $clog2(MAX_WINDOW + 1);

  lidtpf_pkg::cmd_t    cmd;
  lidtpf_pkg::status_t st;
  logic [IW-1:0]       rd_idx;

  assign cfg_ready_o = 1'b1;

  lidtpf_ctrl #(.MAX_WINDOW(MAX_WINDOW), .IW(IW)) u_ctrl (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_stall_o,
    .scan_end_i,
    .st_i     (st),
    .cmd_o    (cmd),
    .rd_idx_o (rd_idx)
  );

  lidtpf_dp #(.MAX_WINDOW(MAX_WINDOW), .IW(IW)) u_dp (
    .clk_i,
    .rst_ni,
    .distance_i,
    .cfg_valid_i,
    .cfg_index_i,
    .cfg_data_i,
    .out_stall_i,
    .out_valid_o,
    .filtered_distance_o,
    .scan_last_o,
    .cmd_i    (cmd),
    .rd_idx_i (rd_idx),
    .st_o     (st)
  );

endmodule

[hdl/lidtpf_ctrl.sv]
// Sequencer of the trailing point filter: judge, emit and flush steps.
module lidtpf_ctrl #(
  parameter int MAX_WINDOW = lidtpf_pkg::MAX_WINDOW_DEF,
  parameter int IW         = $clog2(MAX_WINDOW + 1)
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic                scan_end_i,
  input  lidtpf_pkg::status_t st_i,
  output lidtpf_pkg::cmd_t    cmd_o,
  output logic [IW-1:0]       rd_idx_o
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_D     = 4'd1;
  localparam logic [3:0] S_PREV  = 4'd2;
  localparam logic [3:0] S_NEXT  = 4'd3;
  localparam logic [3:0] S_DEN   = 4'd4;
  localparam logic [3:0] S_MLO   = 4'd5;
  localparam logic [3:0] S_MHI   = 4'd6;
  localparam logic [3:0] S_DEC   = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_FLUSH = 4'd9;

  logic [3:0]                  state_q, state_d;
  logic [IW-1:0]               a_q, a_d;
  logic [lidtpf_pkg::SEEN_W-1:0] k_q, k_d;
  logic                        end_q, end_d;
  logic [IW-1:0]               h_ix, two_h_ix, flush_start;
  logic [lidtpf_pkg::SEEN_W-1:0] h_k, two_h_k;

  assign h_ix        = IW'(st_i.h);
  assign two_h_ix    = IW'({st_i.h, 1'b0});
  assign h_k         = lidtpf_pkg::SEEN_W'(st_i.h);
  assign two_h_k     = lidtpf_pkg::SEEN_W'({st_i.h, 1'b0});
  assign flush_start = (k_q < h_k) ? IW'(k_q) : h_ix;
  assign in_stall_o  = (state_q != S_IDLE);

  always_comb begin
    cmd_o    = '0;
    rd_idx_o = h_ix;
    state_d  = state_q;
    a_d      = a_q;
    k_d      = k_q;
    end_d    = end_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.shift = 1'b1;
          k_d         = st_i.seen;
          end_d       = scan_end_i;
          state_d     = S_D;
        end
      end
      S_D: begin
        if (st_i.enabled && (k_q >= two_h_k)) begin
          cmd_o.ld_d = 1'b1;
          state_d    = S_PREV;
        end else begin
          state_d = S_OUT;
        end
      end
      S_PREV: begin
        rd_idx_o      = h_ix - IW'(1);
        cmd_o.ld_prev = 1'b1;
        state_d       = S_NEXT;
      end
      S_NEXT: begin
        rd_idx_o = h_ix + IW'(1);
        if (st_i.skip) begin
          state_d = S_OUT;
        end else begin
          cmd_o.clr_cnt = 1'b1;
          a_d           = '0;
          state_d       = S_DEN;
        end
      end
      S_DEN: begin
        rd_idx_o = a_q;
        if (a_q == h_ix) begin
          a_d = a_q + IW'(1);
        end else begin
          cmd_o.ld_den = 1'b1;
          state_d      = S_MLO;
        end
      end
      S_MLO: begin
        cmd_o.ld_plo = 1'b1;
        state_d      = S_MHI;
      end
      S_MHI: begin
        cmd_o.cmp       = 1'b1;
        cmd_o.side_left = (a_q > h_ix);
        if (a_q == two_h_ix) begin
          state_d = S_DEC;
        end else begin
          a_d     = a_q + IW'(1);
          state_d = S_DEN;
        end
      end
      S_DEC: begin
        cmd_o.set_marks = st_i.drop;
        state_d         = S_OUT;
      end
      S_OUT: begin
        rd_idx_o = h_ix + IW'(1);
        if (k_q > h_k) begin
          if (st_i.out_free) begin
            cmd_o.emit = 1'b1;
            if (end_q) begin
              a_d     = flush_start;
              state_d = S_FLUSH;
            end else begin
              state_d = S_IDLE;
            end
          end
        end else if (end_q) begin
          a_d     = flush_start;
          state_d = S_FLUSH;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_FLUSH: begin
        rd_idx_o = a_q;
        if (st_i.out_free) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = (a_q == '0);
          if (a_q == '0) begin
            cmd_o.clear = 1'b1;
            state_d     = S_IDLE;
          end else begin
            a_d = a_q - IW'(1);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      a_q     <= '0;
      k_q     <= '0;
      end_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      a_q     <= a_d;
      k_q     <= k_d;
      end_q   <= end_d;
    end
  end

endmodule

[hdl/lidtpf_dp.sv]
// Datapath of the trailing point filter: window, marks, tangent test, output register.
module lidtpf_dp #(
  parameter int MAX_WINDOW = lidtpf_pkg::MAX_WINDOW_DEF,
  parameter int IW         = $clog2(MAX_WINDOW + 1)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic [lidtpf_pkg::DIST_W-1:0]        distance_i,
  input  logic                                 cfg_valid_i,
  input  logic [lidtpf_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [lidtpf_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                                 out_stall_i,
  output logic                                 out_valid_o,
  output logic [lidtpf_pkg::DIST_W-1:0]        filtered_distance_o,
  output logic                                 scan_last_o,
  input  lidtpf_pkg::cmd_t                     cmd_i,
  input  logic [IW-1:0]                        rd_idx_i,
  output lidtpf_pkg::status_t                  st_o
);

  localparam int DEPTH = MAX_WINDOW + 1;
  localparam int CW    = IW + 1;
  localparam int PLO_W = lidtpf_pkg::THR_W + lidtpf_pkg::HALF_W;
  localparam int PHI_W = lidtpf_pkg::THR_W + lidtpf_pkg::DEN_W - lidtpf_pkg::HALF_W;
  localparam int PRD_W = lidtpf_pkg::THR_W + lidtpf_pkg::DEN_W + 1;
  localparam int LHS_W = lidtpf_pkg::DIST_W + lidtpf_pkg::SIN_W;

  logic [lidtpf_pkg::WL_W-1:0]   wl_q;
  logic [lidtpf_pkg::LVL_W-1:0]  lvl_q;
  logic [lidtpf_pkg::RATE_W-1:0] rate_q;
  logic [lidtpf_pkg::DIST_W-1:0] win_q [DEPTH];
  logic [DEPTH-1:0]              mark_q;
  logic [lidtpf_pkg::SEEN_W-1:0] seen_q;
  logic [lidtpf_pkg::DIST_W-1:0] d_q;
  logic [lidtpf_pkg::DEN_W-1:0]  dc_q, den_q;
  logic [LHS_W-1:0]              lhs_q;
  logic [PLO_W-1:0]              plo_q;
  logic                          prev_ok_q;
  logic [CW-1:0]                 left_q, right_q;
  logic                          out_valid_q, out_last_q;
  logic [lidtpf_pkg::DIST_W-1:0] out_dist_q;

  lidtpf_pkg::level_t            lvl;
  lidtpf_pkg::rate_t             rate;
  logic [lidtpf_pkg::DIST_W-1:0] rd_data, diff;
  logic                          next_ok, less, wl_ok, clear;
  logic [lidtpf_pkg::DEN_W-1:0]  nq, den_d;
  logic [PHI_W-1:0]              phi;
  logic [PRD_W-1:0]              prod, lhs_sh;
  logic [IW-1:0]                 h_ix;
  logic [lidtpf_pkg::WL_W-1:0]   wl_new;

  assign lvl     = lidtpf_pkg::level_lookup(lvl_q);
  assign rate    = lidtpf_pkg::rate_lookup(rate_q);
  assign rd_data = win_q[rd_idx_i];
  assign h_ix    = IW'(wl_q[lidtpf_pkg::WL_W-1:1]);
  assign diff    = (d_q > rd_data) ? d_q - rd_data : rd_data - d_q;
  assign next_ok = (diff < lidtpf_pkg::DIST_W'(rate.limit));
  assign nq      = {rd_data, lidtpf_pkg::FRAC_W'(0)};
  assign den_d   = (nq >= dc_q) ? nq - dc_q : dc_q - nq;
  assign phi     = lvl.thr * den_q[lidtpf_pkg::DEN_W-1:lidtpf_pkg::HALF_W];
  assign prod    = {PHI_W'(phi), lidtpf_pkg::HALF_W'(0)} + PRD_W'(plo_q);
  assign lhs_sh  = PRD_W'({lhs_q, lidtpf_pkg::FRAC_W'(0)});
  assign less    = (lhs_sh < prod);
  assign wl_new  = cfg_data_i[lidtpf_pkg::WL_W-1:0];
  assign wl_ok   = wl_new[0] && (wl_new >= lidtpf_pkg::WL_MIN) &&
                   (32'(wl_new) <= MAX_WINDOW);
  assign clear   = cmd_i.clear ||
                   (cfg_valid_i && (cfg_index_i == lidtpf_pkg::CFG_WINDOW) && wl_ok);

  assign st_o.out_free = !out_valid_q || !out_stall_i;
  assign st_o.enabled  = lvl.ok && rate.ok;
  assign st_o.skip     = (d_q == '0) ||
                         (prev_ok_q && next_ok && (d_q > lidtpf_pkg::EXEMPT_RANGE));
  assign st_o.drop     = (left_q >= CW'(lvl.need)) || (right_q >= CW'(lvl.need));
  assign st_o.h        = wl_q[lidtpf_pkg::WL_W-1:1];
  assign st_o.seen     = seen_q;

  assign out_valid_o         = out_valid_q;
  assign filtered_distance_o = out_dist_q;
  assign scan_last_o         = out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wl_q   <= lidtpf_pkg::WL_RESET;
      lvl_q  <= '0;
      rate_q <= lidtpf_pkg::RATE_RESET;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        lidtpf_pkg::CFG_WINDOW: if (wl_ok) wl_q <= wl_new;
        lidtpf_pkg::CFG_LEVEL:  lvl_q  <= cfg_data_i[lidtpf_pkg::LVL_W-1:0];
        lidtpf_pkg::CFG_RATE:   rate_q <= cfg_data_i[lidtpf_pkg::RATE_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) win_q[i] <= '0;
      mark_q <= '0;
      seen_q <= '0;
    end else if (clear) begin
      for (int i = 0; i < DEPTH; i++) win_q[i] <= '0;
      mark_q <= '0;
      seen_q <= '0;
    end else if (cmd_i.shift) begin
      for (int i = DEPTH - 1; i > 0; i--) win_q[i] <= win_q[i-1];
      win_q[0] <= distance_i;
      mark_q   <= {mark_q[DEPTH-2:0], 1'b0};
      seen_q   <= (seen_q < lidtpf_pkg::SEEN_MAX) ? seen_q + 1'b1 : seen_q;
    end else if (cmd_i.set_marks) begin
      for (int i = 0; i < DEPTH; i++) begin
        if ((IW'(i) == h_ix - IW'(1)) || (IW'(i) == h_ix) || (IW'(i) == h_ix + IW'(1)))
          mark_q[i] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.ld_d) begin
      d_q   <= rd_data;
      dc_q  <= rd_data * rate.c;
      lhs_q <= rd_data * rate.s;
    end
    if (cmd_i.ld_prev) prev_ok_q <= next_ok;
    if (cmd_i.ld_den)  den_q <= den_d;
    if (cmd_i.ld_plo)  plo_q <= lvl.thr * den_q[lidtpf_pkg::HALF_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (cmd_i.clr_cnt) begin
      left_q  <= '0;
      right_q <= '0;
    end else if (cmd_i.cmp && less) begin
      if (cmd_i.side_left) left_q <= left_q + CW'(1);
      else                 right_q <= right_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_dist_q <= mark_q[rd_idx_i] ? '0 : rd_data;
      out_last_q <= cmd_i.emit_last;
    end
  end

endmodule

[dv/lidar_trailing_point_filter_test.sv]
// Self-checking testbench for the lidar trailing point filter with a scoreboard-based predictor.
module lidar_trailing_point_filter_test;
  timeunit 1ns;
  timeprecision 1ps;

  class trail_scoreboard;
    bit [3:0]    wlen;
    bit [2:0]    lvl;
    bit [4:0]    rate;
    bit [15:0]   win[16];
    bit          marks[16];
    int unsigned seen;
    bit [16:0]   expq[$];
    int          mism;
    int          checked;
    int          drops;

    function void clear_stream();
      foreach (win[i]) begin
        win[i] = '0;
        marks[i] = 1'b0;
      end
      seen = 0;
    endfunction

    function void reset();
      wlen = 4'd5;
      lvl  = 3'd0;
      rate = 5'd10;
      clear_stream();
    endfunction

    function void write_reg(bit [lidtpf_pkg::CFG_IDX_W-1:0] idx,
                            bit [lidtpf_pkg::CFG_DATA_W-1:0] v);
      bit [3:0] w;
      w = v[3:0];
      if (idx == lidtpf_pkg::CFG_WINDOW) begin
        if (w[0] && w >= 4'd3 && w <= 4'(lidtpf_pkg::MAX_WINDOW_DEF)) begin
          wlen = w;
          clear_stream();
        end
      end else if (idx == lidtpf_pkg::CFG_LEVEL) begin
        lvl = v[2:0];
      end else if (idx == lidtpf_pkg::CFG_RATE) begin
        rate = v;
      end
    endfunction

    function void judge(int h);
      bit [63:0]  thr, s, c, dc, nq, den;
      bit [127:0] lhs, rhs;
      int         need, limit, left, right;
      bit [15:0]  d;
      left = 0;
      right = 0;
      case (lvl)
        3'd1: begin thr = 56272425;  need = 3; end
        3'd2: begin thr = 56272425;  need = 2; end
        3'd3: begin thr = 103389578; need = 2; end
        3'd4: begin thr = 170063998; need = 2; end
        3'd5: begin thr = 170063998; need = 1; end
        default: return;
      endcase
      case (rate)
        5'd10: begin s = 2226350; c = 1073739516; limit = 15; end
        5'd15: begin s = 3339521; c = 1073736631; limit = 30; end
        5'd20: begin s = 4452690; c = 1073732592; limit = 25; end
        5'd25: begin s = 5565853; c = 1073727398; limit = 35; end
        5'd30: begin s = 6679011; c = 1073721051; limit = 40; end
        default: return;
      endcase
      d = win[h];
      if (d == 0) return;
      if (absd(d, win[h-1]) < limit && absd(d, win[h+1]) < limit && d > 16'd500) return;
      lhs = (128'(d) * 128'(s)) << 30;
      dc = 64'(d) * c;
      for (int a = 0; a <= 2 * h; a++) begin
        if (a == h) continue;
        nq = 64'(win[a]) << 30;
        den = nq >= dc ? nq - dc : dc - nq;
        rhs = 128'(thr) * 128'(den);
        if (lhs < rhs) begin
          if (a > h) left++;
          else right++;
        end
      end
      if (left >= need || right >= need) begin
        marks[h-1] = 1'b1;
        marks[h]   = 1'b1;
        marks[h+1] = 1'b1;
        drops++;
      end
    endfunction

    function int absd(bit [15:0] a, bit [15:0] b);
      return a > b ? int'(a - b) : int'(b - a);
    endfunction

    function void note_request(bit [15:0] pt_dist, bit last);
      int unsigned h, k, rem;
      h = wlen / 2;
      k = seen;
      for (int a = 15; a > 0; a--) begin
        win[a] = win[a-1];
        marks[a] = marks[a-1];
      end
      win[0] = pt_dist;
      marks[0] = 1'b0;
      seen = k < 31 ? k + 1 : 31;
      if (k >= 2 * h) judge(h);
      if (k >= h + 1) expq.push_back({marks[h+1] ? 16'd0 : win[h+1], 1'b0});
      if (last) begin
        rem = (k + 1 < h + 1) ? k + 1 : h + 1;
        for (int a = int'(rem) - 1; a >= 0; a--)
          expq.push_back({marks[a] ? 16'd0 : win[a], a == 0});
        clear_stream();
      end
    endfunction

    function void check_result(bit [15:0] fd, bit last);
      bit [16:0] e;
      checked++;
      if (expq.size() == 0) begin
        mism++;
        if (mism <= 10) $display("unexpected result: distance %0d last %0b", fd, last);
        return;
      end
      e = expq.pop_front();
      if (e != {fd, last}) begin
        mism++;
        if (mism <= 10)
          $display("mismatch: expected distance %0d last %0b, got distance %0d last %0b",
                   e[16:1], e[0], fd, last);
      end
    endfunction
  endclass

  logic                              clk_i;
  logic                              rst_ni;
  logic                              in_valid_i;
  logic                              in_stall_o;
  logic [lidtpf_pkg::DIST_W-1:0]     distance_i;
  logic                              scan_end_i;
  logic                              out_valid_o;
  logic                              out_stall_i;
  logic [lidtpf_pkg::DIST_W-1:0]     filtered_distance_o;
  logic                              scan_last_o;
  logic                              cfg_valid_i;
  logic                              cfg_ready_o;
  logic [lidtpf_pkg::CFG_IDX_W-1:0]  cfg_index_i;
  logic [lidtpf_pkg::CFG_DATA_W-1:0] cfg_data_i;

  trail_scoreboard sb;
  int snd_idle;
  int rcv_idle;
  int quiet_cycles;
  int requests;

  lidar_trailing_point_filter u_dut (.*);

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(0, 99) < rcv_idle);
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (in_valid_i && !in_stall_o) begin
        sb.note_request(distance_i, scan_end_i);
        requests <= requests + 1;
      end
      if (out_valid_o && !out_stall_i) begin
        sb.check_result(filtered_distance_o, scan_last_o);
      end
      if (quiet_cycles > 20000) begin
        $display("timeout: no progress");
        $display("*** FAILED ***");
        $finish;
      end
    end
  end

  task automatic send_point(bit [15:0] d, bit last);
    while ($urandom_range(0, 99) < snd_idle) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_i <= d;
    scan_end_i <= last;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expq.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
  endtask

  task automatic write_reg(bit [lidtpf_pkg::CFG_IDX_W-1:0] idx,
                           bit [lidtpf_pkg::CFG_DATA_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.write_reg(idx, v);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic configure(bit [4:0] w, bit [4:0] l, bit [4:0] r);
    drain();
    write_reg(lidtpf_pkg::CFG_WINDOW, w);
    write_reg(lidtpf_pkg::CFG_LEVEL, l);
    write_reg(lidtpf_pkg::CFG_RATE, r);
  endtask

  task automatic random_scans(int count);
    int        left;
    int        base;
    int        pick;
    bit [15:0] d;
    left = count;
    base = $urandom_range(400, 3000);
    while (left > 0) begin
      pick = $urandom_range(0, 99);
      if (pick < 65) base = base + $urandom_range(0, 20) - 10;
      else if (pick < 85) base = $urandom_range(100, 8000);
      if (base < 1) base = 1;
      if (pick >= 85 && pick < 93) d = 16'd0;
      else if (pick >= 93) d = 16'($urandom);
      else d = 16'(base);
      left--;
      send_point(d, left == 0 || $urandom_range(0, 19) == 0);
    end
  endtask

  initial begin
    sb = new();
    sb.reset();
    snd_idle = 8;
    rcv_idle = 69;
    quiet_cycles = 0;
    requests = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    distance_i = '0;
    scan_end_i = 1'b0;
    out_stall_i = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = lidtpf_pkg::CFG_WINDOW;
    cfg_data_i = '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_point(16'd1234, 1'b1);
    send_point(16'd65535, 1'b0);
    send_point(16'd0, 1'b1);
    configure(5'd3, 5'd5, 5'd10);
    send_point(16'd1000, 1'b0);
    send_point(16'd1005, 1'b0);
    send_point(16'd1003, 1'b0);
    send_point(16'd3000, 1'b0);
    send_point(16'd0, 1'b0);
    send_point(16'd65535, 1'b0);
    send_point(16'd200, 1'b0);
    send_point(16'd205, 1'b0);
    send_point(16'd210, 1'b1);
    configure(5'd15, 5'd1, 5'd30);
    send_point(16'd1, 1'b0);
    send_point(16'd65535, 1'b1);
    configure(5'd4, 5'd7, 5'd31);
    for (int i = 0; i < 8; i++) send_point(16'(600 + i * 900), i == 7);
    configure(5'd31, 5'd0, 5'd0);
    send_point(16'd42, 1'b1);

    configure(5'd5, 5'd5, 5'd10);
    random_scans(16);
    configure(5'd7, 5'd3, 5'd15);
    random_scans(16);
    snd_idle = 69;
    rcv_idle = 8;
    configure(5'd9, 5'd4, 5'd20);
    random_scans(16);
    configure(5'd3, 5'd2, 5'd25);
    random_scans(16);
    snd_idle = 0;
    rcv_idle = 0;
    configure(5'd15, 5'd5, 5'd30);
    random_scans(16);
    configure(5'd11, 5'd1, 5'd10);
    random_scans(16);
    drain();

    $display("covered %0d input points and %0d results, %0d points judged as trailing",
             requests, sb.checked, sb.drops);
    $display("window sizes 3 to 15, all levels and rates, short scans and flushes");
    if (sb.mism == 0 && sb.expq.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.mism, sb.expq.size());
      $display("*** FAILED ***");
    end
    $finish;
  end
endmodule

[files.f]
hdl/lidtpf_pkg.sv
hdl/lidtpf_ctrl.sv
hdl/lidtpf_dp.sv
hdl/lidar_trailing_point_filter.sv
dv/lidar_trailing_point_filter_test.sv
